// File: rtl/core/i2cdw_pkg.sv
// Shared types, constants and helper functions for the I2C display write master.
// Used by i2cdw_step and i2c_display_write_master_top; depends on nothing else.
package i2cdw_pkg;

    // Bus timing in ticks.
    localparam int unsigned EDGE_TICKS  = 5;
    localparam int unsigned SETUP_TICKS = 2;
    localparam int unsigned MAX_TICKS   = (EDGE_TICKS > SETUP_TICKS) ? EDGE_TICKS : SETUP_TICKS;
    // The tick counter must be able to hold the longest segment length itself.
    localparam int unsigned WAIT_W      = $clog2(MAX_TICKS + 1);

    localparam logic [WAIT_W-1:0] EDGE_LEN  = WAIT_W'(EDGE_TICKS);
    localparam logic [WAIT_W-1:0] SETUP_LEN = WAIT_W'(SETUP_TICKS);

    // Transaction phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_BIT   = 3'd2;
    localparam logic [2:0] PH_ACK   = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_COMMAND_CONTROL = 2'd1;
    localparam logic [1:0] CFG_DATA_CONTROL    = 2'd2;

    localparam logic [7:0] RST_DEVICE_ADDRESS  = 8'h78;
    localparam logic [7:0] RST_COMMAND_CONTROL = 8'h00;
    localparam logic [7:0] RST_DATA_CONTROL    = 8'h40;

    localparam logic [1:0] BYTE_CONTROL = 2'd1;
    localparam logic [1:0] BYTE_LAST    = 2'd3;

    typedef struct packed {
        logic [2:0]        phase;
        logic [1:0]        segment;
        logic [WAIT_W-1:0] wait_count;
        logic [2:0]        bit_index;
        logic [1:0]        byte_index;
        logic [7:0]        shift_byte;
        logic [7:0]        held_payload;
        logic              held_type;
        logic [2:0]        ack_bits;
        logic              scl;
        logic              sda;
    } t_state;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] command_control;
        logic [7:0] data_control;
    } t_cfg;

    typedef struct packed {
        logic       request_valid;
        logic       req_type;
        logic [7:0] payload;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       accepted;
        logic       done_res;
        logic [2:0] ack_flags;
    } t_result;

    // Length in ticks of the current segment of a phase.
    function automatic logic [WAIT_W-1:0] seg_len(input logic [2:0] phase,
                                                  input logic [1:0] segment);
        logic [WAIT_W-1:0] len;
        len = EDGE_LEN;
        if (phase == PH_BIT || phase == PH_ACK) begin
            if (segment == 2'd1) begin
                len = EDGE_LEN;
            end else if (phase == PH_ACK && segment == 2'd2) begin
                len = EDGE_LEN;
            end else begin
                len = SETUP_LEN;
            end
        end
        return len;
    endfunction

endpackage

// File: rtl/core/i2cdw_step.sv
// Next-state and result logic for one tick of the I2C display write master.
// Purely combinational; uses types and constants from i2cdw_pkg.
module i2cdw_step
    import i2cdw_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_next,
    output t_result o_result
);

    t_state            s;
    logic              acc;
    logic              busy;
    logic              done;
    logic [WAIT_W:0]   wait_sum;
    logic [1:0]        byte_next;

    always_comb begin
        s         = i_state;
        acc       = 1'b0;
        busy      = 1'b0;
        done      = 1'b0;
        wait_sum  = '0;
        byte_next = s.byte_index + 2'd1;

        if (s.phase == PH_IDLE && i_item.request_valid) begin
            acc            = 1'b1;
            s.held_type    = i_item.req_type;
            s.held_payload = i_item.payload;
            s.ack_bits     = '0;
            s.byte_index   = '0;
            s.bit_index    = '0;
            s.wait_count   = '0;
            s.phase        = PH_START;
            s.segment      = '0;
            byte_next      = 2'd1;
        end

        if (s.phase != PH_IDLE) begin
            busy = 1'b1;

            // Line levels for the segment this tick belongs to.
            unique case (s.phase)
                PH_START: begin
                    s.scl = (s.segment != 2'd2);
                    s.sda = (s.segment == 2'd0);
                end
                PH_BIT: begin
                    s.scl = (s.segment == 2'd1);
                    s.sda = s.shift_byte[7];
                end
                PH_ACK: begin
                    s.scl = (s.segment == 2'd1);
                    s.sda = 1'b1;
                end
                PH_STOP: begin
                    s.scl = 1'b1;
                    s.sda = (s.segment != 2'd0);
                end
                default: begin
                    s.scl = i_state.scl;
                    s.sda = i_state.sda;
                end
            endcase

            wait_sum     = {1'b0, s.wait_count} + (WAIT_W+1)'(1);
            s.wait_count = wait_sum[WAIT_W-1:0];

            if (wait_sum >= {1'b0, seg_len(s.phase, s.segment)}) begin
                s.wait_count = '0;
                unique case (s.phase)
                    PH_START: begin
                        if (s.segment < 2'd2) begin
                            s.segment = s.segment + 2'd1;
                        end else begin
                            s.shift_byte = i_cfg.device_address;
                            s.bit_index  = '0;
                            s.phase      = PH_BIT;
                            s.segment    = '0;
                        end
                    end
                    PH_BIT: begin
                        if (s.segment < 2'd2) begin
                            s.segment = s.segment + 2'd1;
                        end else begin
                            s.shift_byte = {s.shift_byte[6:0], 1'b0};
                            s.segment    = '0;
                            if (s.bit_index == 3'd7) begin
                                s.bit_index = '0;
                                s.phase     = PH_ACK;
                            end else begin
                                s.bit_index = s.bit_index + 3'd1;
                            end
                        end
                    end
                    PH_ACK: begin
                        // The acknowledge is sampled on the last tick of SCL high.
                        if (s.segment == 2'd1 && !i_item.sda_sample) begin
                            s.ack_bits = s.ack_bits | 3'(3'b001 << s.byte_index);
                        end
                        if (s.segment < 2'd2) begin
                            s.segment = s.segment + 2'd1;
                        end else begin
                            s.byte_index = byte_next;
                            s.segment    = '0;
                            if (byte_next == BYTE_LAST) begin
                                s.phase = PH_STOP;
                            end else begin
                                s.bit_index = '0;
                                s.phase     = PH_BIT;
                                if (byte_next == BYTE_CONTROL) begin
                                    s.shift_byte = s.held_type ? i_cfg.data_control
                                                               : i_cfg.command_control;
                                end else begin
                                    s.shift_byte = s.held_payload;
                                end
                            end
                        end
                    end
                    PH_STOP: begin
                        if (s.segment < 2'd1) begin
                            s.segment = s.segment + 2'd1;
                        end else begin
                            s.phase   = PH_IDLE;
                            s.segment = '0;
                            done      = 1'b1;
                        end
                    end
                    default: begin
                        s.phase = PH_IDLE;
                    end
                endcase
            end
        end

        o_next             = s;
        o_result.scl_level = s.scl;
        o_result.sda_level = s.sda;
        o_result.busy_res  = busy;
        o_result.accepted  = acc;
        o_result.done_res  = done;
        o_result.ack_flags = s.ack_bits;
    end

endmodule

// File: rtl/core/i2c_display_write_master_top.sv
// Top level of the I2C display write master: input register, bus state, result register.
// Depends on i2cdw_pkg and i2cdw_step.
//
//  channel | direction | handshake                  | content
//  --------+-----------+----------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_ready    | request, type, payload, SDA sample
//  out     | from block| o_out_valid / i_out_ready  | SCL, SDA, busy, accepted, done, acks
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | register index and 8-bit data
//
// A tick's result is registered: the input register feeds the step logic, whose output
// lands in the result register when that register can advance.
// One tick is accepted per cycle while the input ready is high.
// Reset is synchronous and active low; it clears the bus state and both valid flags.
// When the result is not taken, the result register and then the input register hold,
// and the input ready drops only when both are full.
module i2c_display_write_master_top
    import i2cdw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_request_valid,
    input  logic       i_req_type,
    input  logic [7:0] i_payload,
    input  logic       i_sda_sample,

    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_accepted,
    output logic       o_done_res,
    output logic [2:0] o_ack_flags,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic    r_in_valid;
    t_item   r_item;
    t_state  r_state;
    t_state  n_state;
    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_result;
    t_result n_result;
    logic    w_advance;

    assign w_advance   = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    i2cdw_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_next   (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.request_valid <= i_request_valid;
            r_item.req_type      <= i_req_type;
            r_item.payload       <= i_payload;
            r_item.sda_sample    <= i_sda_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Everything cleared except the two line levels, which come up released high.
            r_state     <= {{($bits(t_state) - 2){1'b0}}, 2'b11};
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address  <= RST_DEVICE_ADDRESS;
            r_cfg.command_control <= RST_COMMAND_CONTROL;
            r_cfg.data_control    <= RST_DATA_CONTROL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEVICE_ADDRESS:  r_cfg.device_address  <= i_cfg_data;
                CFG_COMMAND_CONTROL: r_cfg.command_control <= i_cfg_data;
                CFG_DATA_CONTROL:    r_cfg.data_control    <= i_cfg_data;
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_level = r_result.scl_level;
    assign o_sda_level = r_result.sda_level;
    assign o_busy_res  = r_result.busy_res;
    assign o_accepted  = r_result.accepted;
    assign o_done_res  = r_result.done_res;
    assign o_ack_flags = r_result.ack_flags;

endmodule

// File: bench/i2cdw_bus_checker.sv
// Checker for the I2C display write master: predicts the bus levels and flags of each tick.
// Watches the input, result and register channels of the block; depends on i2cdw_pkg.
module i2cdw_bus_checker
    import i2cdw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_request_valid,
    input  logic       i_req_type,
    input  logic [7:0] i_payload,
    input  logic       i_sda_sample,

    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_scl_level,
    input  logic       i_sda_level,
    input  logic       i_busy_res,
    input  logic       i_accepted,
    input  logic       i_done_res,
    input  logic [2:0] i_ack_flags,

    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,

    output int         o_fail_count,
    output int         o_pending,
    output logic       o_bus_active,
    output int         o_ticks,
    output int         o_starts,
    output int         o_stops,
    output int         o_nacks
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register copies.
    logic [7:0] addr_reg;
    logic [7:0] cmd_ctrl_reg;
    logic [7:0] data_ctrl_reg;

    // Bus master state.
    logic [2:0]  bus_phase;
    logic [1:0]  seg;
    int unsigned tick_cnt;
    logic [2:0]  bit_pos;
    logic [1:0]  byte_pos;
    logic [7:0]  shifter;
    logic [7:0]  held_byte;
    logic        held_kind;
    logic [2:0]  ack_seen;
    logic        scl_q;
    logic        sda_q;

    t_result bus_levels_due[$];

    int mismatch_total = 0;
    int due_count      = 0;
    int tick_total     = 0;
    int start_total    = 0;
    int stop_total     = 0;
    int nack_total     = 0;

    assign o_fail_count = mismatch_total;
    assign o_pending    = due_count;
    assign o_bus_active = (bus_phase != PH_IDLE);
    assign o_ticks      = tick_total;
    assign o_starts     = start_total;
    assign o_stops      = stop_total;
    assign o_nacks      = nack_total;

    task automatic report_mismatch(input string msg);
        mismatch_total++;
        $display("[%0t] result %0d: %s", $realtime, tick_total - due_count, msg);
    endtask

    task automatic step_bus_master(input t_item tick, output t_result res);
        int unsigned seg_ticks;
        logic        taken;
        logic        finished;
        taken    = 1'b0;
        finished = 1'b0;
        if (bus_phase == PH_IDLE && tick.request_valid) begin
            taken     = 1'b1;
            held_kind = tick.req_type;
            held_byte = tick.payload;
            ack_seen  = 3'b000;
            byte_pos  = 2'd0;
            bit_pos   = 3'd0;
            tick_cnt  = 0;
            bus_phase = PH_START;
            seg       = 2'd0;
            start_total++;
        end
        res.busy_res = (bus_phase != PH_IDLE);
        if (bus_phase != PH_IDLE) begin
            case (bus_phase)
                PH_START: begin
                    scl_q = (seg != 2'd2);
                    sda_q = (seg == 2'd0);
                end
                PH_BIT: begin
                    scl_q = (seg == 2'd1);
                    sda_q = shifter[7];
                end
                PH_ACK: begin
                    scl_q = (seg == 2'd1);
                    sda_q = 1'b1;
                end
                default: begin
                    scl_q = 1'b1;
                    sda_q = (seg != 2'd0);
                end
            endcase
            // Start and stop parts, SCL high in a bit and the last two ack parts are long.
            if ((bus_phase == PH_BIT || bus_phase == PH_ACK) &&
                !(seg == 2'd1 || (bus_phase == PH_ACK && seg == 2'd2))) begin
                seg_ticks = SETUP_TICKS;
            end else begin
                seg_ticks = EDGE_TICKS;
            end
            tick_cnt++;
            if (tick_cnt >= seg_ticks) begin
                tick_cnt = 0;
                case (bus_phase)
                    PH_START: begin
                        if (seg < 2'd2) begin
                            seg++;
                        end else begin
                            shifter   = addr_reg;
                            bit_pos   = 3'd0;
                            bus_phase = PH_BIT;
                            seg       = 2'd0;
                        end
                    end
                    PH_BIT: begin
                        if (seg < 2'd2) begin
                            seg++;
                        end else begin
                            shifter = shifter << 1;
                            seg     = 2'd0;
                            if (bit_pos == 3'd7) begin
                                bit_pos   = 3'd0;
                                bus_phase = PH_ACK;
                            end else begin
                                bit_pos++;
                            end
                        end
                    end
                    PH_ACK: begin
                        // The slave's answer is read at the end of the SCL-high part.
                        if (seg == 2'd1) begin
                            if (!tick.sda_sample) begin
                                ack_seen[byte_pos] = 1'b1;
                            end else begin
                                nack_total++;
                            end
                        end
                        if (seg < 2'd2) begin
                            seg++;
                        end else begin
                            byte_pos++;
                            seg = 2'd0;
                            if (byte_pos == BYTE_LAST) begin
                                bus_phase = PH_STOP;
                            end else begin
                                if (byte_pos == BYTE_CONTROL) begin
                                    shifter = held_kind ? data_ctrl_reg : cmd_ctrl_reg;
                                end else begin
                                    shifter = held_byte;
                                end
                                bit_pos   = 3'd0;
                                bus_phase = PH_BIT;
                            end
                        end
                    end
                    default: begin
                        if (seg < 2'd1) begin
                            seg++;
                        end else begin
                            bus_phase = PH_IDLE;
                            seg       = 2'd0;
                            finished  = 1'b1;
                            stop_total++;
                        end
                    end
                endcase
            end
        end
        res.scl_level = scl_q;
        res.sda_level = sda_q;
        res.accepted  = taken;
        res.done_res  = finished;
        res.ack_flags = ack_seen;
    endtask

    always @(posedge i_clk) begin : watch
        t_item   tick;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            addr_reg      = RST_DEVICE_ADDRESS;
            cmd_ctrl_reg  = RST_COMMAND_CONTROL;
            data_ctrl_reg = RST_DATA_CONTROL;
            bus_phase     = PH_IDLE;
            seg           = 2'd0;
            tick_cnt      = 0;
            bit_pos       = 3'd0;
            byte_pos      = 2'd0;
            shifter       = 8'h00;
            held_byte     = 8'h00;
            held_kind     = 1'b0;
            ack_seen      = 3'b000;
            scl_q         = 1'b1;
            sda_q         = 1'b1;
            bus_levels_due.delete();
            due_count     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEVICE_ADDRESS:  addr_reg      = i_cfg_data;
                    CFG_COMMAND_CONTROL: cmd_ctrl_reg  = i_cfg_data;
                    CFG_DATA_CONTROL:    data_ctrl_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.scl_level = i_scl_level;
                got.sda_level = i_sda_level;
                got.busy_res  = i_busy_res;
                got.accepted  = i_accepted;
                got.done_res  = i_done_res;
                got.ack_flags = i_ack_flags;
                if (bus_levels_due.size() == 0) begin
                    report_mismatch("result arrived with no tick outstanding");
                end else begin
                    want = bus_levels_due.pop_front();
                    if (got.scl_level !== want.scl_level)
                        report_mismatch($sformatf("scl got %b want %b",
                                                  got.scl_level, want.scl_level));
                    if (got.sda_level !== want.sda_level)
                        report_mismatch($sformatf("sda got %b want %b",
                                                  got.sda_level, want.sda_level));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch($sformatf("busy got %b want %b",
                                                  got.busy_res, want.busy_res));
                    if (got.accepted !== want.accepted)
                        report_mismatch($sformatf("accepted got %b want %b",
                                                  got.accepted, want.accepted));
                    if (got.done_res !== want.done_res)
                        report_mismatch($sformatf("done got %b want %b",
                                                  got.done_res, want.done_res));
                    if (got.ack_flags !== want.ack_flags)
                        report_mismatch($sformatf("ack flags got %b want %b",
                                                  got.ack_flags, want.ack_flags));
                end
            end
            if (i_in_valid && i_in_ready) begin
                tick.request_valid = i_request_valid;
                tick.req_type      = i_req_type;
                tick.payload       = i_payload;
                tick.sda_sample    = i_sda_sample;
                step_bus_master(tick, want);
                bus_levels_due.push_back(want);
                tick_total++;
            end
            due_count = bus_levels_due.size();
        end
    end

endmodule

// File: bench/i2c_display_write_master_top_test.sv
// Testbench top for the I2C display write master: clock, reset, stimulus and verdict.
// Depends on i2cdw_pkg, i2c_display_write_master_top and i2cdw_bus_checker.
module i2c_display_write_master_top_test;
    import i2cdw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime HALF_PERIOD  = 4ns;
    localparam int      RESET_CYCLES = 10;
    localparam int      LONG_HOLD    = 200;
    localparam int      QUIET_LIMIT  = 2000;
    localparam int      DRAIN_CYCLES = 8;
    localparam int      STRETCH_TICKS = 120;
    localparam int      TRANSFER_TICKS = 3 * EDGE_TICKS
                                       + 3 * (8 * (2 * SETUP_TICKS + EDGE_TICKS)
                                              + SETUP_TICKS + 2 * EDGE_TICKS)
                                       + 2 * EDGE_TICKS;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_NOISE} t_sda_mode;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       request_valid = 1'b0;
    logic       req_type = 1'b0;
    logic [7:0] payload = 8'h00;
    logic       sda_sample = 1'b0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       accepted;
    logic       done_res;
    logic [2:0] ack_flags;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'h00;

    int   fail_count;
    int   pending;
    logic bus_active;
    int   ticks;
    int   starts;
    int   stops;
    int   nacks;

    int   burst_left    = 0;
    bit   steady_feed   = 1'b0;
    int   hold_asks     = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    int   pattern_left  = 0;
    int   stall_style   = 0;
    int   quiet_cycles  = 0;
    int   cfg_writes    = 0;
    int   setting_count = 1;

    i2c_display_write_master_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_request_valid (request_valid),
        .i_req_type      (req_type),
        .i_payload       (payload),
        .i_sda_sample    (sda_sample),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_scl_level     (scl_level),
        .o_sda_level     (sda_level),
        .o_busy_res      (busy_res),
        .o_accepted      (accepted),
        .o_done_res      (done_res),
        .o_ack_flags     (ack_flags),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    i2cdw_bus_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_request_valid (request_valid),
        .i_req_type      (req_type),
        .i_payload       (payload),
        .i_sda_sample    (sda_sample),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_scl_level     (scl_level),
        .i_sda_level     (sda_level),
        .i_busy_res      (busy_res),
        .i_accepted      (accepted),
        .i_done_res      (done_res),
        .i_ack_flags     (ack_flags),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bus_active    (bus_active),
        .o_ticks         (ticks),
        .o_starts        (starts),
        .o_stops         (stops),
        .o_nacks         (nacks)
    );

    always #HALF_PERIOD clk = ~clk;

    // Result side: stretches of free flow, light stalls and heavy stalls, plus a long
    // hold whenever the stimulus asks for one.
    always @(negedge clk) begin : receiver
        logic ready_next;
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 160);
                stall_style  = $urandom_range(0, 2);
            end
            pattern_left--;
            case (stall_style)
                0:       ready_next = 1'b1;
                1:       ready_next = ($urandom_range(0, 3) != 0);
                default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
        end
        out_ready <= ready_next;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transaction on any channel for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one tick and returns at the falling edge after it was taken.
    task automatic send_tick(input logic req, input logic kind, input logic [7:0] byte_val,
                             input logic sda);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = (steady_feed || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        request_valid <= req;
        req_type      <= kind;
        payload       <= byte_val;
        sda_sample    <= sda;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic pause_for_results();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // One whole bus write from the request tick to the stop tick.
    task automatic run_transfer(input logic kind, input logic [7:0] byte_val,
                                input t_sda_mode mode, input bit busy_requests);
        logic sda;
        for (int n = 0; n < TRANSFER_TICKS; n++) begin
            case (mode)
                SDA_LOW:  sda = 1'b0;
                SDA_HIGH: sda = 1'b1;
                default:  sda = 1'($urandom_range(0, 1));
            endcase
            if (n == 0) begin
                send_tick(1'b1, kind, byte_val, sda);
            end else begin
                send_tick(busy_requests, 1'($urandom_range(0, 1)), 8'($urandom), sda);
            end
        end
    endtask

    task automatic random_stretch(input int count);
        repeat (count) begin
            send_tick($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)), 8'($urandom),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Runs idle ticks until the bus write in flight has ended, then drains the results.
    task automatic settle_idle();
        while (bus_active) begin
            send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
        end
        pause_for_results();
    endtask

    task automatic load_settings(input logic [7:0] dev, input logic [7:0] cmd,
                                 input logic [7:0] dat, input bit poke_unused);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        int         count;
        idx   = '{CFG_DEVICE_ADDRESS, CFG_COMMAND_CONTROL, CFG_DATA_CONTROL, CFG_UNUSED};
        val   = '{dev, cmd, dat, 8'($urandom)};
        count = poke_unused ? 4 : 3;
        for (int k = 0; k < count; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!(cfg_valid && cfg_ready));
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        cfg_writes += count;
        setting_count++;
        @(negedge clk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset settings: lines held high while idle, an all-ACK
        // command write of zeros, then an all-NACK data write of ones that is flooded with
        // ignored requests, followed at once by another write on the very next tick.
        repeat (3) send_tick(1'b0, 1'b1, 8'hFF, 1'($urandom_range(0, 1)));
        run_transfer(1'b0, 8'h00, SDA_LOW, 1'b0);
        steady_feed = 1'b1;
        hold_asks++;
        run_transfer(1'b1, 8'hFF, SDA_HIGH, 1'b1);
        steady_feed = 1'b0;
        run_transfer(1'($urandom_range(0, 1)), 8'($urandom), SDA_NOISE, 1'b0);
        repeat (2) send_tick(1'b0, 1'b0, 8'h00, 1'b0);
        pause_for_results();

        load_settings(8'h00, 8'h00, 8'h00, 1'b1);
        random_stretch(STRETCH_TICKS);
        settle_idle();

        load_settings(8'hFF, 8'hFF, 8'hFF, 1'b0);
        random_stretch(STRETCH_TICKS);
        settle_idle();

        repeat (2) begin
            load_settings(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            random_stretch(STRETCH_TICKS);
            settle_idle();
        end

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d bus ticks: %0d writes started, %0d stop conditions,",
                 ticks, starts, stops);
        $display("%0d missed acknowledges; register writes: %0d over %0d settings.",
                 nacks, cfg_writes, setting_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
